// ===== hdl/touch_controller_i2c_registers_defines.svh =====
// Shared assertion macros for the touch register block.
`ifndef TOUCH_CONTROLLER_I2C_REGISTERS_DEFINES_SVH
`define TOUCH_CONTROLLER_I2C_REGISTERS_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch register check failed");

// Next-cycle implication, disabled while reset is low.
`define TCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch register check failed");

`endif

// ===== hdl/tcr_pkg.sv =====
package tcr_pkg;

    localparam int TOUCH_POINTS = 2;
    localparam int FRAME_LEN    = 11;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    // Register map
    localparam logic [7:0] ADDR_MODE      = 8'h00;
    localparam logic [7:0] ADDR_FRAME     = 8'h02;
    localparam logic [7:0] ADDR_FRAME_END = 8'h0C;
    localparam logic [7:0] ADDR_THRESHOLD = 8'h80;
    localparam logic [7:0] ADDR_PERIOD    = 8'h88;
    localparam logic [7:0] ADDR_FIRMWARE  = 8'hA6;
    localparam logic [7:0] ADDR_VENDOR    = 8'hA8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRMWARE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VENDOR   = 1'b1;

    localparam logic [7:0] RST_FIRMWARE  = 8'h01;
    localparam logic [7:0] RST_VENDOR    = 8'h11;
    localparam logic [7:0] RST_THRESHOLD = 8'd22;
    localparam logic [7:0] RST_PERIOD    = 8'd4;

    localparam logic [15:0] X_MAX       = 16'd799;
    localparam logic [15:0] Y_MAX       = 16'd479;
    localparam logic [7:0]  WEIGHT_CODE = 8'h40;

    localparam logic [7:0] ACT_DOWN = 8'd1;
    localparam logic [7:0] ACT_UP   = 8'd3;

    typedef enum logic [2:0] {
        FN_START_WR = 3'd0,
        FN_START_RD = 3'd1,
        FN_STOP     = 3'd2,
        FN_WRITE    = 3'd3,
        FN_READ     = 3'd4,
        FN_TOUCH    = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        EV_DOWN    = 2'd0,
        EV_UP      = 2'd1,
        EV_CONTACT = 2'd2
    } t_event;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  bus_byte;
        logic [7:0]  touch_action;
        logic [15:0] touch_x;
        logic [15:0] touch_y;
        logic [7:0]  finger;
        logic        batch_last;
    } t_item;

    typedef logic [FRAME_LEN-1:0][7:0] t_frame;

endpackage

// ===== hdl/tcr_bus.sv =====
module tcr_bus import tcr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_en,
    input  t_item                i_item,
    input  t_frame               i_frame,
    output logic [7:0]           o_read_byte,
    output logic                 o_release
);

    logic [7:0] r_ptr, n_ptr;
    logic       r_await, n_await;
    logic [7:0] r_mode, n_mode;
    logic [7:0] r_thr, n_thr;
    logic [7:0] r_per, n_per;
    logic [7:0] r_fw;
    logic [7:0] r_vendor;
    logic [7:0] reg_value;
    logic [7:0] ptr_off;

    assign ptr_off = r_ptr - ADDR_FRAME;

    always_comb begin
        reg_value = '0;
        if (r_ptr >= ADDR_FRAME && r_ptr <= ADDR_FRAME_END) begin
            reg_value = i_frame[ptr_off[3:0]];
        end else begin
            unique case (r_ptr)
                ADDR_MODE:      reg_value = r_mode;
                ADDR_THRESHOLD: reg_value = r_thr;
                ADDR_PERIOD:    reg_value = r_per;
                ADDR_FIRMWARE:  reg_value = r_fw;
                ADDR_VENDOR:    reg_value = r_vendor;
                default:        reg_value = '0;
            endcase
        end
    end

    always_comb begin
        n_ptr       = r_ptr;
        n_await     = r_await;
        n_mode      = r_mode;
        n_thr       = r_thr;
        n_per       = r_per;
        o_read_byte = '0;
        o_release   = 1'b0;
        if (i_en) begin
            unique case (i_item.func)
                FN_START_WR: n_await = 1'b1;
                FN_STOP:     o_release = (r_ptr == ADDR_FRAME);
                FN_WRITE: begin
                    if (r_await) begin
                        n_ptr   = i_item.bus_byte;
                        n_await = 1'b0;
                    end else begin
                        // unlisted addresses drop the data but still advance
                        if (r_ptr == ADDR_MODE)      n_mode = i_item.bus_byte;
                        if (r_ptr == ADDR_THRESHOLD) n_thr  = i_item.bus_byte;
                        if (r_ptr == ADDR_PERIOD)    n_per  = i_item.bus_byte;
                        n_ptr = r_ptr + 8'd1;
                    end
                end
                FN_READ: begin
                    o_read_byte = reg_value;
                    n_ptr       = r_ptr + 8'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_await  <= 1'b1;
            r_mode   <= '0;
            r_thr    <= RST_THRESHOLD;
            r_per    <= RST_PERIOD;
            r_fw     <= RST_FIRMWARE;
            r_vendor <= RST_VENDOR;
        end else begin
            r_ptr   <= n_ptr;
            r_await <= n_await;
            r_mode  <= n_mode;
            r_thr   <= n_thr;
            r_per   <= n_per;
            if (i_cfg_we && i_cfg_index == CFG_FIRMWARE) r_fw     <= i_cfg_wdata;
            if (i_cfg_we && i_cfg_index == CFG_VENDOR)   r_vendor <= i_cfg_wdata;
        end
    end

endmodule

// ===== hdl/tcr_touch.sv =====
module tcr_touch import tcr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_item  i_item,
    output t_frame o_frame,
    output logic   o_rebuild
);

    logic [15:0] r_x [TOUCH_POINTS];
    logic [15:0] r_y [TOUCH_POINTS];
    logic [TOUCH_POINTS-1:0] r_down, r_touched;
    t_event      r_event [TOUCH_POINTS];
    t_frame      r_frame;

    logic [15:0] n_x [TOUCH_POINTS];
    logic [15:0] n_y [TOUCH_POINTS];
    logic [TOUCH_POINTS-1:0] n_down, n_touched;
    t_event      n_event [TOUCH_POINTS];
    t_frame      n_frame;
    logic        fid_ok;
    logic        fid;
    logic [3:0][7:0] slot0_bytes, slot1_bytes;
    t_event      ev0, ev1;

    // Four slot bytes of one finger with clamped coordinates.
    function automatic logic [3:0][7:0] slot_bytes(input logic [15:0] x, input logic [15:0] y,
                                                    input t_event ev, input logic f);
        logic [15:0] xc;
        logic [15:0] yc;
        xc = (x > X_MAX) ? X_MAX : x;
        yc = (y > Y_MAX) ? Y_MAX : y;
        slot_bytes[0] = {ev, 2'b00, xc[11:8]};
        slot_bytes[1] = xc[7:0];
        slot_bytes[2] = {3'b000, f, yc[11:8]};
        slot_bytes[3] = yc[7:0];
    endfunction

    assign fid_ok    = (i_item.finger[7:1] == '0);
    assign fid       = i_item.finger[0];
    assign o_rebuild = i_en && (i_item.func == FN_TOUCH) && i_item.batch_last;
    assign o_frame   = r_frame;

    always_comb begin
        for (int f = 0; f < TOUCH_POINTS; f++) begin
            n_x[f]     = r_x[f];
            n_y[f]     = r_y[f];
            n_event[f] = r_event[f];
        end
        n_down    = r_down;
        n_touched = r_touched;
        if (i_en && i_item.func == FN_TOUCH && fid_ok) begin
            n_touched[fid] = 1'b1;
            n_x[fid]       = i_item.touch_x;
            n_y[fid]       = i_item.touch_y;
            n_down[fid]    = (i_item.touch_action != ACT_UP);
            if (i_item.touch_action == ACT_DOWN)    n_event[fid] = EV_DOWN;
            else if (i_item.touch_action == ACT_UP) n_event[fid] = EV_UP;
            else                                    n_event[fid] = EV_CONTACT;
        end
    end

    // Frame from the contact state after this report
    always_comb begin
        ev0         = n_touched[0] ? n_event[0] : EV_CONTACT;
        ev1         = n_touched[1] ? n_event[1] : EV_CONTACT;
        slot0_bytes = slot_bytes(n_x[0], n_y[0], ev0, 1'b0);
        slot1_bytes = slot_bytes(n_x[1], n_y[1], ev1, 1'b1);
        n_frame     = '0;
        n_frame[0]  = {6'b0, 2'(n_down[0]) + 2'(n_down[1])};
        if (n_down[0]) begin
            n_frame[4:1] = slot0_bytes;
            n_frame[5]   = WEIGHT_CODE;
            if (n_down[1]) n_frame[10:7] = slot1_bytes;
        end else if (n_down[1]) begin
            n_frame[4:1] = slot1_bytes;
            n_frame[5]   = WEIGHT_CODE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < TOUCH_POINTS; f++) begin
                r_x[f]     <= '0;
                r_y[f]     <= '0;
                r_event[f] <= EV_CONTACT;
            end
            r_down    <= '0;
            r_touched <= '0;
            r_frame   <= '0;
        end else begin
            for (int f = 0; f < TOUCH_POINTS; f++) begin
                r_x[f]     <= n_x[f];
                r_y[f]     <= n_y[f];
                r_event[f] <= o_rebuild ? EV_CONTACT : n_event[f];
            end
            r_down    <= n_down;
            r_touched <= o_rebuild ? '0 : n_touched;
            if (o_rebuild) r_frame <= n_frame;
        end
    end

endmodule

// ===== hdl/touch_controller_i2c_registers.sv =====
// Path: an input transfer is held in the input register, then its result in the
// result register, which drives the output.
// Throughput: one item per cycle while results drain; the input and result
// registers decouple the two sides, so a stalled result still lets one item in.
// Reset: synchronous, active low; clears both channels and the touch frame,
// sets the register map to its reset values, drives the interrupt line high.
module touch_controller_i2c_registers import tcr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] func, [10:3] bus_byte, [18:11] touch_action, [34:19] touch_x,
    // [50:35] touch_y, [58:51] finger, [63:59] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] read_byte, [8] int_level, [15:9] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic       r_in_valid;
    t_item      r_item;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_int;
    logic       r_int, n_int;
    logic       advance;
    logic       in_xfer;
    t_frame     frame;
    logic [7:0] read_byte;
    logic       release_int;
    logic       rebuild;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    tcr_bus u_bus (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_en        (advance),
        .i_item      (r_item),
        .i_frame     (frame),
        .o_read_byte (read_byte),
        .o_release   (release_int)
    );

    tcr_touch u_touch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_item    (r_item),
        .o_frame   (frame),
        .o_rebuild (rebuild)
    );

    always_comb begin
        n_int = r_int;
        if (rebuild)          n_int = 1'b0;
        else if (release_int) n_int = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_int       <= 1'b1;
        end else begin
            r_int <= n_int;
            if (in_xfer)      r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;
            if (advance)            r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.func         <= s_axis_tdata[2:0];
            r_item.bus_byte     <= s_axis_tdata[10:3];
            r_item.touch_action <= s_axis_tdata[18:11];
            r_item.touch_x      <= s_axis_tdata[34:19];
            r_item.touch_y      <= s_axis_tdata[50:35];
            r_item.finger       <= s_axis_tdata[58:51];
            r_item.batch_last   <= s_axis_tlast;
        end
        if (advance) begin
            r_out_byte <= read_byte;
            r_out_int  <= n_int;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_int, r_out_byte};

endmodule

// ===== hdl/tcr_checker.sv =====
`include "touch_controller_i2c_registers_defines.svh"

module tcr_checker import tcr_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // hold a result until it is taken
    `TCR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TCR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // input side only backs up when a result is stalled
    `TCR_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `TCR_ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[15:9] == 7'b0)

endmodule

bind touch_controller_i2c_registers tcr_checker u_tcr_checker (.*);

// ===== verif/tb_touch_controller_i2c_registers.sv =====
`timescale 1ns / 100ps

module tb_touch_controller_i2c_registers;
    import tcr_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASES       = 4;

    typedef struct packed {
        logic       int_level;
        logic [7:0] read_byte;
    } t_bus_reply;

    // Mirror of the register map, finger state and touch frame
    class touch_reg_mirror;
        logic [7:0]  fw_code;
        logic [7:0]  vd_code;
        logic [7:0]  pointer;
        bit          want_addr;
        logic [7:0]  mode_r;
        logic [7:0]  thresh_r;
        logic [7:0]  period_r;
        logic [7:0]  frame [FRAME_LEN];
        logic [15:0] px [TOUCH_POINTS];
        logic [15:0] py [TOUCH_POINTS];
        bit          pressed [TOUCH_POINTS];
        bit          seen [TOUCH_POINTS];
        t_event      pend_ev [TOUCH_POINTS];
        bit          int_n;
        t_bus_reply  replies_due [$];
        int          faults;

        function new();
            fw_code   = RST_FIRMWARE;
            vd_code   = RST_VENDOR;
            pointer   = 8'h00;
            want_addr = 1'b1;
            mode_r    = 8'h00;
            thresh_r  = RST_THRESHOLD;
            period_r  = RST_PERIOD;
            foreach (frame[i]) frame[i] = 8'h00;
            for (int f = 0; f < TOUCH_POINTS; f++) begin
                px[f]      = 16'h0000;
                py[f]      = 16'h0000;
                pressed[f] = 1'b0;
                seen[f]    = 1'b0;
                pend_ev[f] = EV_CONTACT;
            end
            int_n  = 1'b1;
            faults = 0;
        endfunction

        function void set_code(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_FIRMWARE) fw_code = val;
            else if (idx == CFG_VENDOR) vd_code = val;
        endfunction

        function void take_item(logic [IN_DATA_W-1:0] word, logic last);
            logic [2:0]  fn;
            logic [7:0]  b;
            logic [7:0]  act;
            logic [7:0]  fid;
            logic [15:0] x;
            logic [15:0] y;
            logic [15:0] cx;
            logic [15:0] cy;
            logic [7:0]  rd;
            t_event      ev;
            int          slot;
            int          base;
            fn  = word[2:0];
            b   = word[10:3];
            act = word[18:11];
            x   = word[34:19];
            y   = word[50:35];
            fid = word[58:51];
            rd  = 8'h00;
            case (fn)
                FN_START_WR: want_addr = 1'b1;
                FN_STOP: if (pointer == ADDR_FRAME) int_n = 1'b1;
                FN_WRITE: begin
                    if (want_addr) begin
                        pointer   = b;
                        want_addr = 1'b0;
                    end else begin
                        case (pointer)
                            ADDR_MODE:      mode_r   = b;
                            ADDR_THRESHOLD: thresh_r = b;
                            ADDR_PERIOD:    period_r = b;
                            default: ;
                        endcase
                        pointer++;
                    end
                end
                FN_READ: begin
                    if (pointer >= ADDR_FRAME && pointer <= ADDR_FRAME_END) begin
                        rd = frame[pointer - ADDR_FRAME];
                    end else begin
                        case (pointer)
                            ADDR_MODE:      rd = mode_r;
                            ADDR_THRESHOLD: rd = thresh_r;
                            ADDR_PERIOD:    rd = period_r;
                            ADDR_FIRMWARE:  rd = fw_code;
                            ADDR_VENDOR:    rd = vd_code;
                            default:        rd = 8'h00;
                        endcase
                    end
                    pointer++;
                end
                FN_TOUCH: begin
                    if (fid < TOUCH_POINTS) begin
                        seen[fid] = 1'b1;
                        if (act == ACT_DOWN) pend_ev[fid] = EV_DOWN;
                        else if (act == ACT_UP) pend_ev[fid] = EV_UP;
                        else pend_ev[fid] = EV_CONTACT;
                        px[fid]      = x;
                        py[fid]      = y;
                        pressed[fid] = (act != ACT_UP);
                    end
                    if (last) begin
                        // rebuild the frame: down fingers packed in ascending order
                        foreach (frame[i]) frame[i] = 8'h00;
                        slot = 0;
                        for (int f = 0; f < TOUCH_POINTS; f++) begin
                            if (pressed[f]) begin
                                cx   = (px[f] > X_MAX) ? X_MAX : px[f];
                                cy   = (py[f] > Y_MAX) ? Y_MAX : py[f];
                                ev   = seen[f] ? pend_ev[f] : EV_CONTACT;
                                base = 1 + 6 * slot;
                                frame[base]     = {ev, 2'b00, cx[11:8]};
                                frame[base + 1] = cx[7:0];
                                frame[base + 2] = {4'(f), cy[11:8]};
                                frame[base + 3] = cy[7:0];
                                if (slot == 0) frame[base + 4] = WEIGHT_CODE;
                                slot++;
                            end
                        end
                        frame[0] = 8'(slot);
                        for (int f = 0; f < TOUCH_POINTS; f++) begin
                            seen[f]    = 1'b0;
                            pend_ev[f] = EV_CONTACT;
                        end
                        int_n = 1'b0;
                    end
                end
                default: ;
            endcase
            replies_due.push_back({int_n, rd});
        endfunction

        function void check_reply(logic [OUT_DATA_W-1:0] word);
            t_bus_reply want;
            if (replies_due.size() == 0) begin
                faults++;
                if (faults <= 10) $display("unexpected result transfer, data %h", word);
                return;
            end
            want = replies_due.pop_front();
            if (word[7:0] !== want.read_byte || word[8] !== want.int_level) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: expected read_byte %h int_level %b, got %h %b",
                             want.read_byte, want.int_level, word[7:0], word[8]);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [7:0]            i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    touch_reg_mirror regs = new();
    int  sent;
    int  cycles;
    bit  steady;

    touch_controller_i2c_registers DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) regs.take_item(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) regs.check_reply(m_axis_tdata);
        end
    end

    // mostly short gaps, a few long ones, none while steady
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin : sink
        int hold;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold != 0) begin
                hold--;
            end else if (!m_axis_tready) begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 8);
            end else begin
                hold = pick_gap();
                if (hold != 0) m_axis_tready <= 1'b0;
            end
        end
    end

    function automatic t_item rand_item(input logic [2:0] fn);
        t_item it;
        it.func         = fn;
        it.bus_byte     = 8'($urandom);
        it.touch_action = 8'($urandom);
        it.touch_x      = 16'($urandom);
        it.touch_y      = 16'($urandom);
        it.finger       = 8'($urandom);
        it.batch_last   = 1'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, it.finger, it.touch_y, it.touch_x, it.touch_action,
                          it.bus_byte, it.func};
        s_axis_tlast  <= it.batch_last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic bus(input logic [2:0] fn, input logic [7:0] b);
        t_item it;
        it = rand_item(fn);
        it.bus_byte = b;
        send_item(it);
    endtask

    task automatic touch(input logic [7:0] act, input logic [15:0] x, input logic [15:0] y,
                         input logic [7:0] fid, input logic last);
        t_item it;
        it = rand_item(FN_TOUCH);
        it.touch_action = act;
        it.touch_x      = x;
        it.touch_y      = y;
        it.finger       = fid;
        it.batch_last   = last;
        send_item(it);
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (regs.replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_codes(input logic [7:0] fw, input logic [7:0] vd);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FIRMWARE;
        i_cfg_wdata <= fw;
        @(posedge i_clk);
        regs.set_code(CFG_FIRMWARE, fw);
        i_cfg_index <= CFG_VENDOR;
        i_cfg_wdata <= vd;
        @(posedge i_clk);
        regs.set_code(CFG_VENDOR, vd);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stim
        int          first;
        int          next_flip;
        int          n;
        int          pick;
        logic [7:0]  act;
        logic [7:0]  a;
        logic [7:0]  fid;
        logic [15:0] x;
        logic [15:0] y;
        sent   = 0;
        cycles = 0;
        steady = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_wdata   <= 8'h00;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_codes(8'h00, 8'hFF);

        // clamp both axes, plain move, ignored finger closing the batch
        touch(ACT_DOWN, 16'hFFFF, 16'hFFFF, 8'd0, 1'b0);
        touch(8'h00, 16'd0, 16'd0, 8'd1, 1'b0);
        touch(ACT_DOWN, 16'd800, 16'd480, 8'hFF, 1'b1);
        // point at the frame and stop: releases the interrupt
        bus(FN_START_WR, 8'h00);
        bus(FN_WRITE, ADDR_FRAME);
        bus(FN_STOP, 8'hFF);
        bus(FN_START_RD, 8'h00);
        repeat (3) bus(FN_READ, 8'hFF);
        bus(FN_STOP, 8'h00);
        touch(ACT_UP, 16'd799, 16'd479, 8'd0, 1'b1);
        touch(8'hFF, 16'd100, 16'd200, 8'd1, 1'b1);
        // unlisted address write, then pointer wraps into the mode register
        bus(FN_START_WR, 8'hFF);
        bus(FN_WRITE, 8'hFF);
        bus(FN_WRITE, 8'hAB);
        bus(FN_WRITE, 8'h5A);
        bus(3'd6, 8'h00);
        bus(3'd7, 8'hFF);
        bus(FN_START_WR, 8'h00);
        bus(FN_WRITE, ADDR_FIRMWARE);
        bus(FN_START_RD, 8'h00);
        repeat (3) bus(FN_READ, 8'h00);
        bus(FN_STOP, 8'h00);

        first     = sent;
        next_flip = sent;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: set_codes(8'hFF, 8'h00);
                1: set_codes(8'($urandom), 8'($urandom));
                2: set_codes(8'h00, 8'h00);
                default: set_codes(RST_FIRMWARE, RST_VENDOR);
            endcase
            while (sent < first + (ph + 1) * RANDOM_ITEMS / PHASES) begin
                if (sent >= next_flip) begin
                    steady    = ($urandom_range(0, 3) == 0);
                    next_flip = sent + 60;
                end
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    n = $urandom_range(1, 3);
                    for (int k = 0; k < n; k++) begin
                        case ($urandom_range(0, 3))
                            0: act = ACT_DOWN;
                            1: act = 8'd2;
                            2: act = ACT_UP;
                            default: act = 8'($urandom);
                        endcase
                        x   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 900));
                        y   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 560));
                        fid = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 1));
                        touch(act, x, y, fid, k == n - 1);
                    end
                end else if (pick < 60) begin
                    case ($urandom_range(0, 5))
                        0: a = ADDR_MODE;
                        1: a = ADDR_THRESHOLD;
                        2: a = ADDR_PERIOD;
                        3: a = ADDR_THRESHOLD - 8'd1;
                        4: a = ADDR_PERIOD - 8'd1;
                        default: a = 8'($urandom);
                    endcase
                    bus(FN_START_WR, 8'($urandom));
                    bus(FN_WRITE, a);
                    repeat ($urandom_range(0, 3)) bus(FN_WRITE, 8'($urandom));
                    bus(FN_STOP, 8'($urandom));
                end else if (pick < 95) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: a = ADDR_FRAME;
                        4: a = ADDR_FIRMWARE;
                        5: a = ADDR_VENDOR;
                        6: a = ADDR_MODE;
                        7: a = ADDR_THRESHOLD;
                        8: a = ADDR_PERIOD;
                        default: a = 8'($urandom);
                    endcase
                    bus(FN_START_WR, 8'($urandom));
                    bus(FN_WRITE, a);
                    if ($urandom_range(0, 9) != 0) bus(FN_START_RD, 8'($urandom));
                    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    repeat (n) bus(FN_READ, 8'($urandom));
                    bus(FN_STOP, 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 4)) send_item(rand_item(3'($urandom_range(0, 7))));
                end
            end
        end

        settle();
        repeat (6) @(posedge i_clk);
        if (regs.faults == 0 && regs.replies_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
